// ===== rtl/pixel_box_ascii_quantizer_defines.svh =====
// Assertion macros used by the checker file of the box quantiser.
// No dependencies; take in with `include before use.
`ifndef PIXEL_BOX_ASCII_QUANTIZER_DEFINES_SVH
`define PIXEL_BOX_ASCII_QUANTIZER_DEFINES_SVH

// Next-cycle implication, switched off while reset is high.
`define PBAQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pbaq assertion failed");

// Next-cycle implication that also holds across reset.
`define PBAQ_ASSERT_NEXT_RAW(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("pbaq assertion failed");

`endif

// ===== rtl/pbaq_pkg.sv =====
// Shared types, codes and constants of the box quantiser.
// No dependencies; used by the controller, datapath, top level and checker through scoped names.
`timescale 1ns / 1ps

package pbaq_pkg;

   localparam int RGB_W        = 8;
   localparam int IDX_W        = 4;
   localparam int THR_W        = 18;
   localparam int GLYPH_W      = 8;
   localparam int CSR_DATA_W   = 11;
   localparam int CSR_INDEX_W  = 1;
   localparam int ROW_W        = 10;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int GLYPH_SEL_W  = 5;

   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET = 11'd480;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_LEVEL = 1'b1;

   // weighted channel sum and its divide by three
   localparam int WSUM_W       = 19;
   localparam int BRIGHT_W     = 18;
   localparam int RECIP3_W     = 20;
   localparam int RECIP3_SHIFT = 21;
   localparam logic [9:0] WEIGHT_RED   = 10'd650;
   localparam logic [9:0] WEIGHT_GREEN = 10'd510;
   localparam logic [9:0] WEIGHT_BLUE  = 10'd475;
   localparam logic [RECIP3_W-1:0] RECIP3 = 20'd699051;

   localparam logic [GLYPH_W-1:0] GLYPH_NONE = 8'h2E;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WEIGHT,
      ST_DIVIDE,
      ST_ACCUM,
      ST_SCAN,
      ST_EMIT
   } ctl_state_type;

   typedef struct packed {
      logic pix_accept;
      logic lvl_write;
      logic weight_en;
      logic divide_en;
      logic accum_en;
      logic scan_step;
      logic glyph_latch;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic emit;
      logic scan_hit;
      logic scan_last;
      logic out_free;
   } dp_status_type;

   function automatic logic [GLYPH_W-1:0] glyph_of(input logic [GLYPH_SEL_W-1:0] sel);
      logic [GLYPH_W-1:0] code;
      case (sel)
         5'd0:    code = 8'h60;
         5'd1:    code = 8'h7E;
         5'd2:    code = 8'h5E;
         5'd3:    code = 8'h21;
         5'd4:    code = 8'h3A;
         5'd5:    code = 8'h3B;
         5'd6:    code = 8'h28;
         5'd7:    code = 8'h2A;
         5'd8:    code = 8'h2B;
         5'd9:    code = 8'h5D;
         5'd10:   code = 8'h24;
         5'd11:   code = 8'h4F;
         5'd12:   code = 8'h23;
         default: code = 8'h40;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/pbaq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pbaq_ram #(
   parameter int WIDTH = 23,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pbaq_ctl.sv =====
// Sequencer of the box quantiser: steps one item through the datapath.
// Depends on pbaq_pkg.
`timescale 1ns / 1ps

module pbaq_ctl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_opcode,
   output pbaq_pkg::dp_cmd_type   cmd,
   input  pbaq_pkg::dp_status_type sts
);

   pbaq_pkg::ctl_state_type state_ff;
   pbaq_pkg::ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbaq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pbaq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == pbaq_pkg::OP_PIXEL) begin
                  cmd.pix_accept = 1'b1;
                  state_in       = pbaq_pkg::ST_WEIGHT;
               end else begin
                  cmd.lvl_write = 1'b1;
               end
            end
         end
         pbaq_pkg::ST_WEIGHT: begin
            cmd.weight_en = 1'b1;
            state_in      = pbaq_pkg::ST_DIVIDE;
         end
         pbaq_pkg::ST_DIVIDE: begin
            cmd.divide_en = 1'b1;
            state_in      = pbaq_pkg::ST_ACCUM;
         end
         pbaq_pkg::ST_ACCUM: begin
            cmd.accum_en = 1'b1;
            state_in     = sts.emit ? pbaq_pkg::ST_SCAN : pbaq_pkg::ST_IDLE;
         end
         pbaq_pkg::ST_SCAN: begin
            // stop on the first matching level or after the last one
            if (sts.scan_hit || sts.scan_last) begin
               cmd.glyph_latch = 1'b1;
               state_in        = pbaq_pkg::ST_EMIT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         pbaq_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = pbaq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pbaq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/pbaq_dp.sv =====
// Datapath of the box quantiser: position counters, brightness, box sums,
// level table scan and the result register. Depends on pbaq_pkg, pbaq_ram.
`timescale 1ns / 1ps

module pbaq_dp #(
   parameter int BOX_W     = 4,
   parameter int BOX_H     = 8,
   parameter int MAX_WIDTH = 1024,
   parameter int LEVELS    = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pbaq_pkg::dp_cmd_type                 cmd,
   output pbaq_pkg::dp_status_type              sts,
   input  logic [pbaq_pkg::RGB_W-1:0]           req_red,
   input  logic [pbaq_pkg::RGB_W-1:0]           req_green,
   input  logic [pbaq_pkg::RGB_W-1:0]           req_blue,
   input  logic [pbaq_pkg::IDX_W-1:0]           req_level_index,
   input  logic [pbaq_pkg::THR_W-1:0]           req_level_threshold,
   input  logic                                 csr_write_enable,
   input  logic [pbaq_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pbaq_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pbaq_pkg::GLYPH_W-1:0]         rsp_glyph,
   output logic                                 rsp_end_of_row
);

   localparam int BOX_AREA = BOX_W * BOX_H;
   localparam int BOX_COLS = (MAX_WIDTH + BOX_W - 1) / BOX_W;
   localparam int AW       = (BOX_COLS > 1) ? $clog2(BOX_COLS) : 1;
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int EFF_W    = $clog2(MAX_WIDTH + 1);
   localparam int EOR_W    = EFF_W + 5;
   localparam int CX_W     = (BOX_W > 1) ? $clog2(BOX_W) : 1;
   localparam int RY_W     = (BOX_H > 1) ? $clog2(BOX_H) : 1;
   localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int SUM_W    = pbaq_pkg::BRIGHT_W + $clog2(BOX_AREA);
   localparam int TP_W     = pbaq_pkg::THR_W + 1;
   localparam int CMP_W    = TP_W + $clog2(BOX_AREA + 1);
   localparam int DPROD_W  = pbaq_pkg::WSUM_W + pbaq_pkg::RECIP3_W;
   localparam int CW       = pbaq_pkg::CSR_DATA_W;
   localparam logic [CMP_W-1:0] AREA_C = CMP_W'(BOX_AREA);

   // size registers
   logic [CW-1:0] width_ff, width_in, height_ff, height_in;
   logic [EFF_W-1:0] eff_w;
   logic [CW-1:0] eff_h;

   // frame position
   logic [COL_W-1:0] col_ff, col_in;
   logic [CX_W-1:0] cx_ff, cx_in;
   logic [AW-1:0] bx_ff, bx_in;
   logic [pbaq_pkg::ROW_W-1:0] row_ff, row_in;
   logic [RY_W-1:0] ry_ff, ry_in;
   logic col_last, row_last, cx_last, ry_last;

   // per-beat flags and pixel
   logic first_ff, first_in, emit_ff, emit_in, eor_ff, eor_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [pbaq_pkg::RGB_W-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   // brightness and box sum
   logic [pbaq_pkg::WSUM_W-1:0] wsum_ff, wsum_in, red_term, green_term, blue_term;
   logic [DPROD_W-1:0] div_prod;
   logic [pbaq_pkg::BRIGHT_W-1:0] bright_ff, bright_in;
   logic [SUM_W-1:0] sum_ff, sum_in, ram_rdata;

   // level table and scan
   logic [pbaq_pkg::THR_W-1:0] table_ff [LEVELS];
   logic [pbaq_pkg::THR_W-1:0] table_in [LEVELS];
   logic [LVL_W-1:0] k_ff, k_in;
   logic [TP_W-1:0] thr_p1;
   logic [CMP_W-1:0] thr_scaled;
   logic scan_hit;
   logic [pbaq_pkg::GLYPH_W-1:0] res_glyph_ff, res_glyph_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in, rsp_eor_ff, rsp_eor_in;
   logic [pbaq_pkg::GLYPH_W-1:0] rsp_glyph_ff, rsp_glyph_in;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = EFF_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         eff_w = EFF_W'(MAX_WIDTH);
      end else begin
         eff_w = EFF_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = CW'(1);
      end else if (int'(height_ff) > pbaq_pkg::HEIGHT_LIMIT) begin
         eff_h = CW'(pbaq_pkg::HEIGHT_LIMIT);
      end else begin
         eff_h = height_ff;
      end
   end

   assign col_last = (EFF_W'(col_ff) + EFF_W'(1)) >= eff_w;
   assign row_last = (CW'(row_ff) + CW'(1)) >= eff_h;
   assign cx_last  = cx_ff == CX_W'(BOX_W - 1);
   assign ry_last  = ry_ff == RY_W'(BOX_H - 1);

   // size registers and position counters; a size write restarts the frame
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      cx_in     = cx_ff;
      bx_in     = bx_ff;
      row_in    = row_ff;
      ry_in     = ry_ff;
      first_in  = first_ff;
      emit_in   = emit_ff;
      eor_in    = eor_ff;
      addr_in   = addr_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      blue_in   = blue_ff;
      if (csr_write_enable) begin
         case (csr_index)
            pbaq_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_write_data;
            pbaq_pkg::CSR_IMAGE_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
         col_in = '0;
         cx_in  = '0;
         bx_in  = '0;
         row_in = '0;
         ry_in  = '0;
      end else if (cmd.pix_accept) begin
         red_in   = req_red;
         green_in = req_green;
         blue_in  = req_blue;
         addr_in  = bx_ff;
         first_in = ry_ff == '0;
         // a box that ends here lies wholly inside the image
         emit_in  = cx_last && ry_last;
         eor_in   = (EOR_W'(col_ff) + EOR_W'(BOX_W)) >= EOR_W'(eff_w);
         if (col_last) begin
            col_in = '0;
            cx_in  = '0;
            bx_in  = '0;
            if (row_last) begin
               row_in = '0;
               ry_in  = '0;
            end else begin
               row_in = row_ff + pbaq_pkg::ROW_W'(1);
               ry_in  = ry_last ? '0 : ry_ff + RY_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
            cx_in  = cx_last ? '0 : cx_ff + CX_W'(1);
            bx_in  = cx_last ? bx_ff + AW'(1) : bx_ff;
         end
      end
   end

   // brightness: weighted sum, then divide by three through the reciprocal
   assign red_term   = pbaq_pkg::WSUM_W'(red_ff) * pbaq_pkg::WSUM_W'(pbaq_pkg::WEIGHT_RED);
   assign green_term = pbaq_pkg::WSUM_W'(green_ff) * pbaq_pkg::WSUM_W'(pbaq_pkg::WEIGHT_GREEN);
   assign blue_term  = pbaq_pkg::WSUM_W'(blue_ff) * pbaq_pkg::WSUM_W'(pbaq_pkg::WEIGHT_BLUE);
   assign div_prod   = DPROD_W'(wsum_ff) * DPROD_W'(pbaq_pkg::RECIP3);

   assign wsum_in   = cmd.weight_en ? red_term + green_term + blue_term : wsum_ff;
   assign bright_in = cmd.divide_en ? div_prod[pbaq_pkg::RECIP3_SHIFT +: pbaq_pkg::BRIGHT_W]
                                    : bright_ff;
   assign sum_in    = first_ff ? SUM_W'(bright_ff) : ram_rdata + SUM_W'(bright_ff);

   pbaq_ram #(
      .WIDTH (SUM_W),
      .DEPTH (BOX_COLS)
   ) u_box_sums (
      .clock   (clock),
      .wr_en   (cmd.accum_en),
      .wr_addr (addr_ff),
      .wr_data (sum_in),
      .rd_en   (cmd.pix_accept),
      .rd_addr (bx_ff),
      .rd_data (ram_rdata)
   );

   // level table
   always_comb begin
      table_in = table_ff;
      if (cmd.lvl_write && (int'(req_level_index) < LEVELS)) begin
         table_in[LVL_W'(req_level_index)] = req_level_threshold;
      end
   end

   // threshold < sum / area  <=>  (threshold + 1) * area <= sum
   assign thr_p1     = TP_W'(table_ff[k_ff]) + TP_W'(1);
   assign thr_scaled = CMP_W'(thr_p1) * AREA_C;
   assign scan_hit   = thr_scaled <= CMP_W'(sum_ff);

   always_comb begin
      k_in = k_ff;
      if (cmd.accum_en) begin
         k_in = '0;
      end else if (cmd.scan_step) begin
         k_in = k_ff + LVL_W'(1);
      end
   end

   assign res_glyph_in = cmd.glyph_latch
                         ? (scan_hit ? pbaq_pkg::glyph_of(pbaq_pkg::GLYPH_SEL_W'(k_ff))
                                     : pbaq_pkg::GLYPH_NONE)
                         : res_glyph_ff;

   // result register: hold until the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_glyph_in = rsp_glyph_ff;
      rsp_eor_in   = rsp_eor_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_glyph_in = res_glyph_ff;
         rsp_eor_in   = eor_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= pbaq_pkg::WIDTH_RESET;
         height_ff    <= pbaq_pkg::HEIGHT_RESET;
         col_ff       <= '0;
         cx_ff        <= '0;
         bx_ff        <= '0;
         row_ff       <= '0;
         ry_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            table_ff[i] <= '0;
         end
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         cx_ff        <= cx_in;
         bx_ff        <= bx_in;
         row_ff       <= row_in;
         ry_ff        <= ry_in;
         rsp_valid_ff <= rsp_valid_in;
         table_ff     <= table_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      emit_ff      <= emit_in;
      eor_ff       <= eor_in;
      addr_ff      <= addr_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      wsum_ff      <= wsum_in;
      bright_ff    <= bright_in;
      k_ff         <= k_in;
      res_glyph_ff <= res_glyph_in;
      rsp_glyph_ff <= rsp_glyph_in;
      rsp_eor_ff   <= rsp_eor_in;
      if (cmd.accum_en) begin
         sum_ff <= sum_in;
      end
   end

   assign sts.emit      = emit_ff;
   assign sts.scan_hit  = scan_hit;
   assign sts.scan_last = k_ff == LVL_W'(LEVELS - 1);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_glyph      = rsp_glyph_ff;
   assign rsp_end_of_row = rsp_eor_ff;

endmodule

// ===== rtl/pixel_box_ascii_quantizer.sv =====
// Pixel box to ASCII quantiser, top level.
// Depends on pbaq_pkg, pbaq_ctl, pbaq_dp (and pbaq_ram below it).
//
// Pixels enter in raster order, one beat at a time. A pixel beat occupies
// the block through accept, weighting, divide by three and the box sum
// read-modify-write. A pixel that completes a box then scans the level
// table one entry per cycle through a single multiply-compare, and then
// waits, if need be, for the result register to drain. A level table
// write leaves the block idle and ready. The result register decouples
// the output, so the next pixel is taken while a glyph still waits on
// rsp_ready. Box sums live in a RAM of MAX_WIDTH / BOX_W entries, rounded
// up; it needs no clearing after reset since the first row of each band
// overwrites every sum before it is read. Writing either size register
// restarts the frame at the top left pixel.
`timescale 1ns / 1ps

module pixel_box_ascii_quantizer #(
   parameter int BOX_W     = 4,
   parameter int BOX_H     = 8,
   parameter int MAX_WIDTH = 1024,
   parameter int LEVELS    = 14
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [pbaq_pkg::RGB_W-1:0]         req_red,
   input  logic [pbaq_pkg::RGB_W-1:0]         req_green,
   input  logic [pbaq_pkg::RGB_W-1:0]         req_blue,
   input  logic [pbaq_pkg::IDX_W-1:0]         req_level_index,
   input  logic [pbaq_pkg::THR_W-1:0]         req_level_threshold,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pbaq_pkg::GLYPH_W-1:0]       rsp_glyph,
   output logic                               rsp_end_of_row,
   input  logic                               csr_write_enable,
   input  logic [pbaq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pbaq_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   pbaq_pkg::dp_cmd_type    cmd;
   pbaq_pkg::dp_status_type sts;

   pbaq_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .cmd        (cmd),
      .sts        (sts)
   );

   pbaq_dp #(
      .BOX_W     (BOX_W),
      .BOX_H     (BOX_H),
      .MAX_WIDTH (MAX_WIDTH),
      .LEVELS    (LEVELS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_red             (req_red),
      .req_green           (req_green),
      .req_blue            (req_blue),
      .req_level_index     (req_level_index),
      .req_level_threshold (req_level_threshold),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_glyph           (rsp_glyph),
      .rsp_end_of_row      (rsp_end_of_row)
   );

endmodule

// ===== rtl/pbaq_chk.sv =====
// Port-level checker of the box quantiser, bound to the top level.
// Depends on pbaq_pkg and pixel_box_ascii_quantizer_defines.svh.
`timescale 1ns / 1ps
`include "pixel_box_ascii_quantizer_defines.svh"

module pbaq_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               req_opcode,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [pbaq_pkg::GLYPH_W-1:0]       rsp_glyph,
   input logic                               rsp_end_of_row
);

   logic pix_beat, lvl_beat;
   logic [pbaq_pkg::GLYPH_W:0] rsp_payload;

   assign pix_beat    = req_valid && req_ready && (req_opcode == pbaq_pkg::OP_PIXEL);
   assign lvl_beat    = req_valid && req_ready && (req_opcode == pbaq_pkg::OP_LEVEL);
   assign rsp_payload = {rsp_glyph, rsp_end_of_row};

   // a stalled result holds
   `PBAQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   // a pixel keeps the block busy for the next cycle
   `PBAQ_ASSERT_NEXT(a_pixel_busy, pix_beat, !req_ready)
   // a table write never raises a result
   `PBAQ_ASSERT_NEXT(a_level_quiet, lvl_beat && !rsp_valid, !rsp_valid)
   // reset leaves the block empty and ready
   `PBAQ_ASSERT_NEXT_RAW(a_reset_idle, reset, !rsp_valid && req_ready)

endmodule

bind pixel_box_ascii_quantizer pbaq_chk u_pbaq_chk (.*);
